// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each one is clocked on clk and is
// disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mchs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mchs_pkg
// Shared types and constants for the cut height search block.
// ---------------------------------------------------------------------------
package mchs_pkg;

  // Default sizes of the histogram.
  localparam int HEIGHT_LEVELS_DEF = 65536;
  localparam int MAX_TREES_DEF     = 65536;

  // Fixed field widths.
  localparam int HEIGHT_W = 16;
  localparam int REQ_W    = 32;
  localparam int WOOD_W   = 33;

  // Value of the required amount after reset.
  localparam logic [REQ_W-1:0] REQ_RESET = 32'd1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // One scan beat handed to the accumulator.
  typedef struct packed {
    logic valid;
    logic counts;
    logic last_pos;
  } beat_t;

  // Status reported back by the accumulator.
  typedef struct packed {
    logic done;
    logic found;
  } acc_stat_t;

endpackage

// ===== hw/rtl/mchs_hist_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mchs_hist_mem
// Histogram memory: one write port and one read port with registered
// read data. A read and a write of the same entry return the old value.
// ---------------------------------------------------------------------------
module mchs_hist_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 17
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write and registered read in one block, so a same-entry read sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mchs_accum.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mchs_accum
// Scan accumulator: running tree count, then cut wood and the search for
// the first height at which the wood reaches the required amount.
// ---------------------------------------------------------------------------
module mchs_accum import mchs_pkg::*; #(
  parameter int IDX_W     = 16,
  parameter int MAX_TREES = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  beat_t            beat,
  input  logic [$clog2(2*MAX_TREES)-1:0] count,
  input  logic [IDX_W-1:0] pos,
  input  logic [REQ_W-1:0] req,
  output acc_stat_t        stat,
  output logic [IDX_W-1:0] height
);

  localparam int CNT_W = $clog2(2*MAX_TREES);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(2*MAX_TREES-1);
  localparam logic [WOOD_W-1:0] WOOD_MAX = '1;

  logic [CNT_W-1:0]  trees;
  logic [CNT_W:0]    trees_sum;
  logic [CNT_W-1:0]  trees_next;
  logic              b_valid;
  logic              b_counts;
  logic              b_last;
  logic [IDX_W-1:0]  b_pos;
  logic [WOOD_W-1:0] wood;
  logic [WOOD_W:0]   wood_sum;
  logic [WOOD_W-1:0] wood_next;
  logic              found;
  logic              done;

  // Saturating running count of trees at or above the scan height.
  assign trees_sum  = {1'b0, trees} + {1'b0, count};
  assign trees_next = (trees_sum > {1'b0, CNT_MAX}) ? CNT_MAX : trees_sum[CNT_W-1:0];

  // Saturating wood total; the count register already holds this height.
  assign wood_sum  = {1'b0, wood} + (WOOD_W+1)'(trees);
  assign wood_next = wood_sum[WOOD_W] ? WOOD_MAX : wood_sum[WOOD_W-1:0];

  // First stage: tree count.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      trees   <= '0;
      b_valid <= 1'b0;
    end else begin
      b_valid <= beat.valid;
      if (beat.valid && beat.counts) begin
        trees <= trees_next;
      end
    end
    b_counts <= beat.counts;
    b_last   <= beat.last_pos;
    b_pos    <= pos;
  end

  // Second stage: wood, compare and completion.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      wood  <= '0;
      found <= 1'b0;
      done  <= 1'b0;
    end else if (b_valid) begin
      if (b_counts) begin
        wood <= wood_next;
        if (!found && (wood_next >= {1'b0, req})) begin
          found  <= 1'b1;
          height <= b_pos - 1'b1;
        end
      end
      if (b_last) begin
        done <= 1'b1;
      end
    end
  end

  assign stat = '{done: done, found: found};

endmodule

// ===== hw/rtl/max_cut_height_search.sv =====
`timescale 1ns / 1ps
// Result: after the last tree is accepted, the scan runs and the result is registered once the accumulator is done.
// Throughput: one tree per cycle while loading; the scan then takes one histogram
// entry per cycle through the single read port, from the tallest height down to zero.
// Reset: a clearing pass writes every histogram entry before the first tree is
// accepted; configuration writes are taken during it.
// ---------------------------------------------------------------------------
// max_cut_height_search
// Histogram of tree heights in a memory, followed by a downward scan that
// finds the greatest blade height cutting at least the required wood.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module max_cut_height_search import mchs_pkg::*; #(
  parameter int HEIGHT_LEVELS = HEIGHT_LEVELS_DEF,
  parameter int MAX_TREES     = MAX_TREES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [REQ_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [HEIGHT_W-1:0] tree_height,
  input  logic                last_tree,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HEIGHT_W-1:0] cut_height,
  output logic                enough
);

  localparam int IDX_W = $clog2(HEIGHT_LEVELS);
  localparam int CNT_W = $clog2(2*MAX_TREES);
  localparam logic [IDX_W-1:0] LEVEL_MAX = IDX_W'(HEIGHT_LEVELS-1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(2*MAX_TREES-1);

  state_t            state;
  state_t            state_next;
  logic              in_accept;
  logic              out_load;
  logic [REQ_W-1:0]  required_amount;
  logic [IDX_W-1:0]  scan_pos;
  logic [IDX_W-1:0]  tallest;
  logic [31:0]       height_ext;
  logic [IDX_W-1:0]  in_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  rd_data;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic              s1_valid;
  logic              s1_scan;
  logic              s1_counts;
  logic              s1_last;
  logic [IDX_W-1:0]  s1_addr;
  logic              wb_valid;
  logic [IDX_W-1:0]  wb_addr;
  logic [CNT_W-1:0]  wb_data;
  logic [CNT_W-1:0]  cur_count;
  beat_t             beat;
  acc_stat_t         acc_stat;
  logic [IDX_W-1:0]  acc_height;
  logic [IDX_W-1:0]  res_idx;
  logic [31:0]       res_ext;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      required_amount <= REQ_RESET;
    end else if (cfg_write) begin
      required_amount <= cfg_data;
    end
  end

  // Heights beyond the histogram clamp to its top entry.
  assign height_ext = 32'(tree_height);
  assign in_idx = (height_ext > 32'(HEIGHT_LEVELS-1)) ? LEVEL_MAX : height_ext[IDX_W-1:0];

  assign in_accept = in_valid && !in_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (scan_pos == '0) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid && last_tree) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_pos == '0) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (acc_stat.done) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Scan and clear position, and the tallest height of the set.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos <= LEVEL_MAX;
      tallest  <= '0;
    end else begin
      if ((state == ST_CLEAR || state == ST_SCAN) && scan_pos != '0) begin
        scan_pos <= scan_pos - 1'b1;
      end
      if (in_accept) begin
        if (in_idx > tallest) tallest <= in_idx;
        if (last_tree) scan_pos <= (in_idx > tallest) ? in_idx : tallest;
      end
      if (out_load) tallest <= '0;
    end
  end

  // Read issue: the incoming height while loading, the scan position while scanning.
  assign rd_addr = (state == ST_SCAN) ? scan_pos : in_idx;

  // Read data stage with forwarding of the write made in the previous cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (state == ST_SCAN);
      wb_valid <= s1_valid;
    end
    s1_scan   <= (state == ST_SCAN);
    s1_counts <= (scan_pos != '0);
    s1_last   <= (scan_pos == '0);
    s1_addr   <= rd_addr;
    wb_addr   <= s1_addr;
    wb_data   <= mem_wdata;
  end

  assign cur_count = (wb_valid && wb_addr == s1_addr) ? wb_data : rd_data;

  // Write port: saturating increment when loading, zero when scanning or clearing.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr;
    mem_wdata = '0;
    if (s1_valid) begin
      mem_we = 1'b1;
      if (!s1_scan) begin
        mem_wdata = (cur_count < CNT_MAX) ? cur_count + 1'b1 : cur_count;
      end
    end else if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = scan_pos;
    end
  end

  mchs_hist_mem #(
    .DEPTH  (HEIGHT_LEVELS),
    .ADDR_W (IDX_W),
    .DATA_W (CNT_W)
  ) u_hist_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign beat = '{valid: s1_valid && s1_scan, counts: s1_counts, last_pos: s1_last};

  mchs_accum #(
    .IDX_W     (IDX_W),
    .MAX_TREES (MAX_TREES)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .clr    (out_load),
    .beat   (beat),
    .count  (cur_count),
    .pos    (s1_addr),
    .req    (required_amount),
    .stat   (acc_stat),
    .height (acc_height)
  );

  // A zero requirement cuts at the tallest height; a miss reports height zero.
  always_comb begin
    res_idx = '0;
    if (required_amount == '0) begin
      res_idx = tallest;
    end else if (acc_stat.found) begin
      res_idx = acc_height;
    end
  end
  assign res_ext = 32'(res_idx);

  // Output register for the result request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      cut_height <= res_ext[HEIGHT_W-1:0];
      enough     <= (required_amount == '0) || acc_stat.found;
    end
  end

  // Checks on the sequencing.
  `ASSERT_NEXT(a_last_starts_scan, in_accept && last_tree, state == ST_SCAN, "last tree did not start the scan")
  `ASSERT_SAME(a_done_in_drain, acc_stat.done, state == ST_DRAIN || state == ST_RESULT, "scan completion outside drain")
  `ASSERT_SAME(a_scan_beat_state, s1_valid && s1_scan, state == ST_SCAN || state == ST_DRAIN, "scan beat outside the scan")
  `ASSERT_SAME(a_result_from_fsm, $rose(out_valid), $past(state) == ST_RESULT, "result loaded outside result state")

endmodule
